### sv/md5_digest_engine_macros.svh
// Assertion macros for the MD5 digest engine
`ifndef MD5_DIGEST_ENGINE_MACROS_SVH
`define MD5_DIGEST_ENGINE_MACROS_SVH
// assert that cond implies next-cycle result
`define MD5_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
// assert that cond implies same-cycle result
`define MD5_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`endif

### sv/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types and constants of the MD5 digest engine.
// ----------------------------------------------------------------------------
`default_nettype none
package md5_pkg;
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] digest_byte;
    logic       last_byte;
  } out_item_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] t [64];
    t = '{32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
          32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
          32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
          32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
          32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
          32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
          32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
          32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
          32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
          32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
          32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
          32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
          32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
          32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
          32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
          32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return t[i];
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] round_g(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i[3:0] + 1);
      2'd2: g = 4'(3 * i[3:0] + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction
endpackage
`default_nettype wire

### sv/md5_round.sv
// ----------------------------------------------------------------------------
// md5_round
// One MD5 round step: mixing function, adds and left rotate.
// ----------------------------------------------------------------------------
`default_nettype none
module md5_round (
  input  wire logic [5:0]  idx,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  input  wire logic [31:0] c,
  input  wire logic [31:0] d,
  input  wire logic [31:0] m,
  output logic      [31:0] b_new
);
  logic [31:0] f;
  logic [31:0] sum;
  logic [4:0]  s;
  logic [63:0] dbl;

  always_comb begin
    case (idx[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    sum = f + a + md5_pkg::round_k(idx) + m;
    s = md5_pkg::round_s(idx);
    dbl = {sum, sum} << s;
    b_new = b + dbl[63:32];
  end
endmodule
`default_nettype wire

### sv/md5_digest_engine.sv
// ----------------------------------------------------------------------------
// md5_digest_engine
// MD5 over a byte stream, one shared round unit stepped 64 times per block.
// ----------------------------------------------------------------------------
// Use: each in_ transfer carries at most one message byte and an end mark.
// Bytes are stored in a 64-byte block memory; a byte that completes a block
// starts the round sequencer, which steps the single round unit through the
// 64 rounds and then folds the result into the chaining words. The memory is
// read one 32-bit word a cycle, so every round is preceded by a read state
// (S_RD, then S_RND). A plain byte is taken without leaving the idle state;
// a block-completing byte keeps in_ready low until its block is hashed.
// On an end mark the sequencer writes 0x80, zero padding and the 8 length
// bytes one per cycle (hashing one or two blocks), then sends the 16 digest
// bytes, A to D, least significant byte first, last_byte on the final one.
// in_ready is low throughout that work. out_data comes combinationally from
// the chaining words; a stalled receiver simply holds the sequencer in the
// output state. Reset restores the MD5 initial chain and a zero bit count.
// ----------------------------------------------------------------------------
`default_nettype none
`include "md5_digest_engine_macros.svh"
module md5_digest_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire md5_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output md5_pkg::out_item_t     out_data
);
  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_RD, S_RND, S_FOLD, S_OUT
  } state_t;

  state_t      state_r;
  logic [31:0] ch_r [4];
  logic [31:0] rw_r [4];
  logic [63:0] bits_r;
  logic [63:0] len_r;
  logic [5:0]  pos_r;
  logic [5:0]  rnd_r;
  logic        ending_r;
  logic [3:0]  oidx_r;
  logic [31:0] m_r;
  // padding progress: 0x80 written, length goes in the current block
  logic        mark_r;
  logic        len_blk_r;

  // block memory, byte-wide lanes of 16 words
  logic [7:0]  mem0 [16];
  logic [7:0]  mem1 [16];
  logic [7:0]  mem2 [16];
  logic [7:0]  mem3 [16];

  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [31:0] b_new;
  logic [7:0]  pad_sel;
  logic [31:0] oword;

  md5_round u_round (
    .idx(rnd_r), .a(rw_r[0]), .b(rw_r[1]), .c(rw_r[2]), .d(rw_r[3]),
    .m(m_r), .b_new(b_new)
  );

  assign in_ready = (state_r == S_IDLE);

  // padding byte: 0x80 first, length bytes at 56..63 of the length block
  always_comb begin
    if (!mark_r)
      pad_sel = md5_pkg::PAD_BYTE;
    else if (len_blk_r && pos_r >= md5_pkg::LEN_POS)
      pad_sel = 8'(len_r >> {pos_r[2:0], 3'b000});
    else
      pad_sel = 8'h00;
  end

  always_comb begin
    wr_en = 1'b0;
    wr_byte = in_data.data_byte;
    if (state_r == S_IDLE && in_valid && in_data.byte_present) wr_en = 1'b1;
    if (state_r == S_PAD) begin
      wr_en = 1'b1;
      wr_byte = pad_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (pos_r[1:0])
        2'd0: mem0[pos_r[5:2]] <= wr_byte;
        2'd1: mem1[pos_r[5:2]] <= wr_byte;
        2'd2: mem2[pos_r[5:2]] <= wr_byte;
        default: mem3[pos_r[5:2]] <= wr_byte;
      endcase
    end
    m_r <= {mem3[md5_pkg::round_g(rnd_r)], mem2[md5_pkg::round_g(rnd_r)],
            mem1[md5_pkg::round_g(rnd_r)], mem0[md5_pkg::round_g(rnd_r)]};
  end

  assign oword = ch_r[oidx_r[3:2]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ch_r     <= '{md5_pkg::INIT_A, md5_pkg::INIT_B, md5_pkg::INIT_C, md5_pkg::INIT_D};
      rw_r     <= '{32'h0, 32'h0, 32'h0, 32'h0};
      bits_r   <= '0;
      pos_r    <= '0;
      rnd_r    <= '0;
      ending_r <= 1'b0;
      oidx_r   <= '0;
      mark_r   <= 1'b0;
      len_blk_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.byte_present) begin
              bits_r <= bits_r + 64'd8;
              pos_r  <= pos_r + 6'd1;
            end
            if (in_data.end_of_message) begin
              ending_r <= 1'b1;
              len_r <= in_data.byte_present ? bits_r + 64'd8 : bits_r;
            end
            if (in_data.byte_present && pos_r == 6'd63) begin
              rnd_r <= '0;
              rw_r <= ch_r;
              state_r <= S_RD;
            end else if (in_data.end_of_message) begin
              state_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // first pad byte after the message is 0x80
          pos_r <= pos_r + 6'd1;
          if (!mark_r) begin
            mark_r <= 1'b1;
            if (pos_r < md5_pkg::LEN_POS) len_blk_r <= 1'b1;
          end
          if (pos_r == 6'd63) begin
            rnd_r <= '0;
            rw_r <= ch_r;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_RND;
        S_RND: begin
          rw_r[0] <= rw_r[3];
          rw_r[1] <= b_new;
          rw_r[2] <= rw_r[1];
          rw_r[3] <= rw_r[2];
          rnd_r <= rnd_r + 6'd1;
          state_r <= (rnd_r == 6'd63) ? S_FOLD : S_RD;
        end
        S_FOLD: begin
          for (int j = 0; j < 4; j++) ch_r[j] <= ch_r[j] + rw_r[j];
          if (!ending_r) state_r <= S_IDLE;
          else if (len_blk_r) begin
            state_r <= S_OUT;
            oidx_r <= '0;
            out_valid <= 1'b1;
            mark_r <= 1'b0;
            len_blk_r <= 1'b0;
          end else begin
            // no room for the length here: one more padding block
            len_blk_r <= 1'b1;
            state_r <= S_PAD;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            oidx_r <= oidx_r + 4'd1;
            if (oidx_r == 4'd15) begin
              out_valid <= 1'b0;
              ending_r <= 1'b0;
              ch_r <= '{md5_pkg::INIT_A, md5_pkg::INIT_B, md5_pkg::INIT_C,
                         md5_pkg::INIT_D};
              bits_r <= '0;
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    out_data.digest_byte = 8'(oword >> {oidx_r[1:0], 3'b000});
    out_data.last_byte   = (oidx_r == 4'd15);
  end

  `MD5_ASSERT_IMPL(a_busy, clk, rst_n, state_r != S_IDLE, !in_ready, "ready while busy")
  `MD5_ASSERT_IMPL(a_outst, clk, rst_n, out_valid, state_r == S_OUT, "valid outside output")
  `MD5_ASSERT_NEXT(a_rd, clk, rst_n, state_r == S_RD, state_r == S_RND, "read not followed by round")
endmodule
`default_nettype wire
